// ----- rtl/sutp_pkg.sv -----
package sutp_pkg;

  localparam int VALUE_BITS  = 32;
  localparam int OFFSET_BITS = 16;

  localparam int CH_BITS    = 8;
  localparam int RADIX_BITS = 6;
  localparam int IN_DATA_W  = ((CH_BITS + RADIX_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((VALUE_BITS + OFFSET_BITS + 7) / 8) * 8;
  localparam int OUT_USER_W = 2;

  localparam logic [RADIX_BITS-1:0] BASE_AUTO = 6'd0;
  localparam logic [RADIX_BITS-1:0] BASE_ONE  = 6'd1;
  localparam logic [RADIX_BITS-1:0] BASE_OCT  = 6'd8;
  localparam logic [RADIX_BITS-1:0] BASE_DEC  = 6'd10;
  localparam logic [RADIX_BITS-1:0] BASE_HEX  = 6'd16;
  localparam logic [RADIX_BITS-1:0] BASE_MAX  = 6'd36;

  localparam logic [CH_BITS-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_BITS-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CH_BITS-1:0] CH_MINUS = 8'h2D;
  localparam logic [CH_BITS-1:0] CH_X_LO  = 8'h78;
  localparam logic [CH_BITS-1:0] CH_X_UP  = 8'h58;
  localparam logic [CH_BITS-1:0] UP_BIAS  = 8'h41 - 8'd10;
  localparam logic [CH_BITS-1:0] LO_BIAS  = 8'h61 - 8'd10;
  localparam logic [CH_BITS-1:0] NO_DIGIT = 8'hFF;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SPACE,
    PH_SIGNED,
    PH_ZERO,
    PH_ZERO_X,
    PH_DIGITS
  } phase_t;

  typedef struct packed {
    logic [CH_BITS-1:0]    ch;
    logic                  first;
    logic [RADIX_BITS-1:0] radix;
  } in_item_t;

  typedef struct packed {
    phase_t                 phase;
    logic [VALUE_BITS-1:0]  acc;
    logic [RADIX_BITS-1:0]  base;
    logic                   neg;
    logic                   any_digit;
    logic                   ovf;
    logic [OFFSET_BITS-1:0] pos;
  } parse_state_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0]  value;
    logic [OFFSET_BITS-1:0] end_offset;
    logic                   converted;
    logic                   overflowed;
  } result_t;

  function automatic logic is_blank(input logic [CH_BITS-1:0] c);
    return c inside {8'h20, 8'h09, 8'h0A, 8'h0D, 8'h0C, 8'h0B};
  endfunction

  function automatic logic is_hex(input logic [CH_BITS-1:0] c);
    return c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
  endfunction

  function automatic logic [CH_BITS-1:0] digit_value(input logic [CH_BITS-1:0] c);
    logic [CH_BITS-1:0] d;
    if (c inside {[8'h30:8'h39]}) begin
      d = c - CH_ZERO;
    end else if (c inside {[8'h41:8'h5A]}) begin
      d = c - UP_BIAS;
    end else if (c inside {[8'h61:8'h7A]}) begin
      d = c - LO_BIAS;
    end else begin
      d = NO_DIGIT;
    end
    return d;
  endfunction

endpackage

// ----- rtl/sutp_in_stage.sv -----
module sutp_in_stage (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  sutp_pkg::in_item_t                in_item,
  output logic                              item_valid,
  output sutp_pkg::in_item_t                item,
  input  logic                              item_take
);
  import sutp_pkg::*;

  logic     valid_r;
  logic     valid_nxt;
  in_item_t item_r;

  // free when empty or when the held item is consumed this cycle
  assign in_ready = !valid_r || item_take;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (item_take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// ----- rtl/sutp_parser.sv -----
module sutp_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  sutp_pkg::in_item_t  item,
  output logic                res_valid,
  output sutp_pkg::result_t   res
);
  import sutp_pkg::*;

  localparam int PROD_W = VALUE_BITS + RADIX_BITS;

  parse_state_t st_r;
  parse_state_t st_nxt;
  parse_state_t nx;

  logic [OFFSET_BITS-1:0] idx;
  logic [OFFSET_BITS:0]   pos_sum;
  logic [CH_BITS-1:0]     d;
  logic [PROD_W-1:0]      prod;
  logic                   active;
  logic                   lead;
  logic                   do_digit;
  logic                   do_emit;
  logic                   pos_hold;
  logic                   pos_two;

  always_comb begin
    nx        = st_r;
    active    = 1'b0;
    lead      = 1'b0;
    do_digit  = 1'b0;
    do_emit   = 1'b0;
    pos_hold  = 1'b0;
    pos_two   = 1'b0;
    d         = digit_value(item.ch);
    prod      = '0;
    pos_sum   = '0;
    res       = '0;
    res_valid = 1'b0;

    if (item.first) begin
      nx.phase     = PH_SPACE;
      nx.acc       = '0;
      nx.base      = item.radix;
      nx.neg       = 1'b0;
      nx.any_digit = 1'b0;
      nx.ovf       = 1'b0;
      nx.pos       = '0;
      if (item.radix == BASE_ONE || item.radix > BASE_MAX) begin
        do_emit = 1'b1;
      end else begin
        active = 1'b1;
      end
    end else if (st_r.phase != PH_IDLE) begin
      active = 1'b1;
    end
    idx = nx.pos;

    if (active) begin
      case (nx.phase)
        PH_SPACE: begin
          if (is_blank(item.ch)) begin
            // skip
          end else if (item.ch == CH_MINUS) begin
            nx.neg   = 1'b1;
            nx.phase = PH_SIGNED;
          end else if (item.ch == CH_PLUS) begin
            nx.phase = PH_SIGNED;
          end else begin
            lead = 1'b1;
          end
        end
        PH_SIGNED: begin
          lead = 1'b1;
        end
        PH_ZERO: begin
          if (item.ch == CH_X_LO || item.ch == CH_X_UP) begin
            nx.phase = PH_ZERO_X;
            pos_hold = 1'b1;
          end else begin
            if (nx.base == BASE_AUTO) begin
              nx.base = BASE_OCT;
            end
            nx.any_digit = 1'b1;
            do_digit     = 1'b1;
          end
        end
        PH_ZERO_X: begin
          nx.any_digit = 1'b1;
          if (is_hex(item.ch)) begin
            nx.base  = BASE_HEX;
            do_digit = 1'b1;
            pos_two  = 1'b1;
          end else begin
            if (nx.base == BASE_AUTO) begin
              nx.base = BASE_OCT;
            end
            do_emit = 1'b1;
          end
        end
        PH_DIGITS: begin
          do_digit = 1'b1;
        end
        default: begin
        end
      endcase

      if (lead) begin
        if (item.ch == CH_ZERO && (nx.base == BASE_AUTO || nx.base == BASE_HEX)) begin
          nx.phase = PH_ZERO;
        end else begin
          if (nx.base == BASE_AUTO) begin
            nx.base = BASE_DEC;
          end
          do_digit = 1'b1;
        end
      end

      if (do_digit) begin
        if (nx.base == BASE_AUTO || d >= {2'b00, nx.base}) begin
          do_emit = 1'b1;
        end else begin
          prod = ({{RADIX_BITS{1'b0}}, nx.acc} * {{VALUE_BITS{1'b0}}, nx.base})
               + {{(PROD_W - CH_BITS){1'b0}}, d};
          if (!nx.ovf) begin
            if (|prod[PROD_W-1:VALUE_BITS]) begin
              nx.ovf = 1'b1;
            end else begin
              nx.acc = prod[VALUE_BITS-1:0];
            end
          end
          nx.any_digit = 1'b1;
          nx.phase     = PH_DIGITS;
        end
      end
    end

    if (do_emit) begin
      res_valid = 1'b1;
      if (nx.ovf) begin
        res.value = '1;
      end else if (nx.neg) begin
        res.value = '0 - nx.acc;
      end else begin
        res.value = nx.acc;
      end
      res.end_offset = nx.any_digit ? idx : '0;
      res.converted  = nx.any_digit;
      res.overflowed = nx.ovf;
      nx.phase       = PH_IDLE;
    end else if (active && !pos_hold) begin
      pos_sum = {1'b0, idx} + (pos_two ? (OFFSET_BITS+1)'(2) : (OFFSET_BITS+1)'(1));
      nx.pos  = pos_sum[OFFSET_BITS] ? '1 : pos_sum[OFFSET_BITS-1:0];
    end

    st_nxt = step ? nx : st_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{phase: PH_IDLE, acc: '0, base: '0, neg: 1'b0,
                any_digit: 1'b0, ovf: 1'b0, pos: '0};
    end else begin
      st_r <= st_nxt;
    end
  end

endmodule

// ----- rtl/sutp_out_stage.sv -----
module sutp_out_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  sutp_pkg::result_t  res,
  output logic               can_load,
  output logic               out_valid,
  input  logic               out_ready,
  output sutp_pkg::result_t  out_res
);
  import sutp_pkg::*;

  logic    valid_r;
  logic    valid_nxt;
  result_t res_r;

  assign can_load = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load && can_load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

// ----- rtl/saturating_unsigned_text_parser.sv -----
// Streaming strtoul-style parser: one character per transaction, the base
// (0 = detect, 2..36) given with the character flagged first. Leading
// whitespace and one sign are taken, a 0x/0X prefix is honored only when a
// hex digit follows, and the first non-digit (NUL included) yields one
// result: value (all ones on overflow, else two's-complement negated on
// '-'), end offset, converted and overflowed flags. An invalid base gives an
// empty result on the first character. Throughput is one character per
// clock while no result is held back by out_tready; out_tvalid rises once
// the ending character has gone through the input register and then the
// result register. The per-character step, a 32x6 multiply-add with
// carry-out check on the accumulator, sits between those two registers.
// While a result waits in the output register the parser stalls; input
// flow resumes the cycle out_tready rises.
module saturating_unsigned_text_parser (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [sutp_pkg::IN_DATA_W-1:0]      in_tdata,  // ch[7:0], radix[13:8], zero pad
  input  logic                                in_tuser,  // first
  // result channel
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [sutp_pkg::OUT_DATA_W-1:0]     out_tdata, // value, end_offset
  output logic [sutp_pkg::OUT_USER_W-1:0]     out_tuser  // converted, overflowed
);
  import sutp_pkg::*;

  in_item_t in_item;
  in_item_t item;
  logic     item_valid;
  logic     step;
  logic     can_load;
  logic     res_valid;
  result_t  res;
  result_t  out_res;

  assign in_item.ch    = in_tdata[CH_BITS-1:0];
  assign in_item.radix = in_tdata[CH_BITS+RADIX_BITS-1:CH_BITS];
  assign in_item.first = in_tuser;

  // a held character is processed whenever the result register can take
  // whatever it may produce
  assign step = item_valid && can_load;

  sutp_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (step)
  );

  sutp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  sutp_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step && res_valid),
    .res       (res),
    .can_load  (can_load),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  // value in the low bits, offset above it
  assign out_tdata = OUT_DATA_W'({out_res.end_offset, out_res.value});
  assign out_tuser = {out_res.overflowed, out_res.converted};

endmodule

// ----- tb/tb_saturating_unsigned_text_parser.sv -----
module tb_saturating_unsigned_text_parser;
  import sutp_pkg::*;

  // Watchdog: cycles with no transaction on either channel before giving up.
  localparam int STALL_LIMIT = 2000;
  // Output latency is two registers; allow some slack when draining.
  localparam int DRAIN_CYCLES = 8;
  // Traffic mode switches every this many accepted characters.
  localparam int MODE_SPAN = 300;
  localparam int RANDOM_CHARS = 1450;

  localparam logic [CH_BITS-1:0] CH_NUL   = 8'h00;
  localparam logic [CH_BITS-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_BITS-1:0] CH_ALL   = 8'hFF;
  localparam logic [VALUE_BITS-1:0] ALL_ONES = '1;
  localparam logic [OFFSET_BITS-1:0] OFFSET_TOP = '1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                    in_tvalid = 1'b0;
  logic                    in_tready;
  logic [IN_DATA_W-1:0]    in_tdata = '0;   // ch[7:0], radix[13:8], zero pad
  logic                    in_tuser = 1'b0; // first
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic [OUT_DATA_W-1:0]   out_tdata;       // value[31:0], end_offset[47:32]
  logic [OUT_USER_W-1:0]   out_tuser;       // converted, overflowed

  saturating_unsigned_text_parser DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #6 clk = ~clk;

  // Characters waiting to be driven, and parse results still owed by the DUT.
  in_item_t pending_chars[$];
  result_t  expected_results[$];

  int mismatch_count = 0;
  int chars_accepted = 0;
  int idle_cycles = 0;

  // ---------------------------------------------------------------------------
  // Parser predictor: its own copy of the parse state, advanced once per
  // accepted input transaction.
  // ---------------------------------------------------------------------------
  phase_t                 pr_phase = PH_IDLE;
  logic [VALUE_BITS-1:0]  pr_acc = '0;
  logic [RADIX_BITS-1:0]  pr_base = '0;
  logic                   pr_neg = 1'b0;
  logic                   pr_any = 1'b0;
  logic                   pr_ovf = 1'b0;
  logic [OFFSET_BITS-1:0] pr_pos = '0;

  function automatic logic char_is_space(input logic [CH_BITS-1:0] c);
    case (c)
      8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic char_is_hex(input logic [CH_BITS-1:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
  endfunction

  // Worth of a character as a digit; NO_DIGIT when it is none.
  function automatic logic [CH_BITS-1:0] char_weight(input logic [CH_BITS-1:0] c);
    if (c >= "0" && c <= "9") begin
      return c - "0";
    end else if (c >= "A" && c <= "Z") begin
      return c - "A" + 8'd10;
    end else if (c >= "a" && c <= "z") begin
      return c - "a" + 8'd10;
    end
    return NO_DIGIT;
  endfunction

  function automatic logic [OFFSET_BITS-1:0] offset_add(input logic [OFFSET_BITS-1:0] a,
                                                         input int k);
    longint s;
    s = longint'(a) + k;
    return (s > longint'(OFFSET_TOP)) ? OFFSET_TOP : OFFSET_BITS'(s);
  endfunction

  // Parse ends: queue the result and go idle.
  task automatic close_parse(input logic [OFFSET_BITS-1:0] idx);
    result_t r;
    if (pr_ovf) begin
      r.value = ALL_ONES;
    end else if (pr_neg) begin
      r.value = -pr_acc;
    end else begin
      r.value = pr_acc;
    end
    r.end_offset = pr_any ? idx : '0;
    r.converted  = pr_any;
    r.overflowed = pr_ovf;
    expected_results.push_back(r);
    pr_phase = PH_IDLE;
  endtask

  task automatic take_digit(input logic [CH_BITS-1:0] c, input logic [OFFSET_BITS-1:0] idx);
    logic [CH_BITS-1:0] d;
    longint unsigned    lim;
    d = char_weight(c);
    if (pr_base == BASE_AUTO || d >= pr_base) begin
      close_parse(idx);
    end else begin
      // once saturated, digits are consumed but the value stays put
      if (!pr_ovf) begin
        lim = (longint'(ALL_ONES) - d) / pr_base;
        if (pr_acc > lim) begin
          pr_ovf = 1'b1;
        end else begin
          pr_acc = pr_acc * pr_base + d;
        end
      end
      pr_any = 1'b1;
      pr_phase = PH_DIGITS;
    end
  endtask

  // First character after blanks and sign: a '0' may open a prefix.
  task automatic take_lead(input logic [CH_BITS-1:0] c, input logic [OFFSET_BITS-1:0] idx);
    if (c == CH_ZERO && (pr_base == BASE_AUTO || pr_base == BASE_HEX)) begin
      pr_phase = PH_ZERO;
    end else begin
      if (pr_base == BASE_AUTO) begin
        pr_base = BASE_DEC;
      end
      take_digit(c, idx);
    end
  endtask

  task automatic predict_char(input in_item_t it);
    logic [OFFSET_BITS-1:0] idx;
    logic                   done;
    done = 1'b0;
    if (it.first) begin
      pr_acc = '0;
      pr_neg = 1'b0;
      pr_any = 1'b0;
      pr_ovf = 1'b0;
      pr_pos = '0;
      pr_base = it.radix;
      if (it.radix == BASE_ONE || it.radix > BASE_MAX) begin
        // bad base: empty result straight away
        close_parse('0);
        done = 1'b1;
      end else begin
        pr_phase = PH_SPACE;
      end
    end else if (pr_phase == PH_IDLE) begin
      done = 1'b1;
    end
    if (!done) begin
      idx = pr_pos;
      case (pr_phase)
        PH_SPACE: begin
          if (!char_is_space(it.ch)) begin
            if (it.ch == CH_MINUS) begin
              pr_neg = 1'b1;
              pr_phase = PH_SIGNED;
            end else if (it.ch == CH_PLUS) begin
              pr_phase = PH_SIGNED;
            end else begin
              take_lead(it.ch, idx);
            end
          end
        end
        PH_SIGNED: begin
          take_lead(it.ch, idx);
        end
        PH_ZERO: begin
          if (it.ch == CH_X_LO || it.ch == CH_X_UP) begin
            // hold the x; offset stays on it until resolved
            pr_phase = PH_ZERO_X;
            done = 1'b1;
          end else begin
            if (pr_base == BASE_AUTO) begin
              pr_base = BASE_OCT;
            end
            pr_any = 1'b1;
            take_digit(it.ch, idx);
          end
        end
        PH_ZERO_X: begin
          pr_any = 1'b1;
          done = 1'b1;
          if (char_is_hex(it.ch)) begin
            pr_base = BASE_HEX;
            take_digit(it.ch, idx);
            pr_pos = offset_add(idx, 2);
          end else begin
            // lone "0x": the zero counts, the offset points at the x
            close_parse(idx);
          end
        end
        default: begin
          take_digit(it.ch, idx);
        end
      endcase
      if (!done && pr_phase != PH_IDLE) begin
        pr_pos = offset_add(idx, 1);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------------
  logic                  string_open = 1'b0;
  logic [RADIX_BITS-1:0] string_radix = '0;

  // Radix on non-first characters is don't-care; drive junk there.
  task automatic push_char(input logic [CH_BITS-1:0] c, input logic first,
                           input logic [RADIX_BITS-1:0] radix);
    in_item_t it;
    it.ch = c;
    it.first = first;
    it.radix = first ? radix : RADIX_BITS'($urandom_range(0, 63));
    pending_chars.push_back(it);
  endtask

  task automatic begin_string(input logic [RADIX_BITS-1:0] radix);
    string_open = 1'b1;
    string_radix = radix;
  endtask

  task automatic add_char(input logic [CH_BITS-1:0] c);
    push_char(c, string_open, string_radix);
    string_open = 1'b0;
  endtask

  task automatic add_text(input string s, input logic [RADIX_BITS-1:0] radix);
    begin_string(radix);
    for (int i = 0; i < s.len(); i++) begin
      add_char(s[i]);
    end
  endtask

  function automatic logic [CH_BITS-1:0] digit_char(input int d, input bit upper);
    if (d < 10) begin
      return CH_ZERO + CH_BITS'(d);
    end
    return (upper ? 8'h41 : 8'h61) + CH_BITS'(d - 10);
  endfunction

  function automatic logic [CH_BITS-1:0] random_blank();
    case ($urandom_range(0, 5))
      0: return 8'h20;
      1: return 8'h09;
      2: return 8'h0A;
      3: return 8'h0B;
      4: return 8'h0C;
      default: return 8'h0D;
    endcase
  endfunction

  // Well-formed number: blanks, sign, prefix, digits valid for the base, then
  // some terminator.
  task automatic add_number();
    int                    sel;
    int                    n;
    int                    eff;
    bit                    top_digit;
    logic [RADIX_BITS-1:0] rdx;
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1, 2: rdx = BASE_AUTO;
      3: rdx = BASE_DEC;
      4: rdx = BASE_HEX;
      5: rdx = BASE_OCT;
      default: rdx = RADIX_BITS'($urandom_range(2, 36));
    endcase
    begin_string(rdx);
    repeat ($urandom_range(0, 3)) add_char(random_blank());
    case ($urandom_range(0, 2))
      1: add_char(CH_PLUS);
      2: add_char(CH_MINUS);
      default: ;
    endcase
    eff = (rdx == BASE_AUTO) ? 10 : int'(rdx);
    if (rdx == BASE_AUTO || rdx == BASE_HEX) begin
      case ($urandom_range(0, 3))
        1: begin
          add_char(CH_ZERO);
          if (rdx == BASE_AUTO) eff = 8;
        end
        2: begin
          add_char(CH_ZERO);
          add_char($urandom_range(0, 1) ? CH_X_LO : CH_X_UP);
          eff = 16;
        end
        default: ;
      endcase
    end
    // mostly short values; some long enough to saturate
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 14) : $urandom_range(0, 6);
    top_digit = ($urandom_range(0, 7) == 0);
    repeat (n) begin
      add_char(digit_char(top_digit ? eff - 1 : $urandom_range(0, eff - 1),
                          1'($urandom_range(0, 1))));
    end
    case ($urandom_range(0, 3))
      0: add_char(CH_NUL);
      1: add_char(CH_SPACE);
      2: add_char(CH_ALL);
      default: add_char(CH_BITS'($urandom_range(0, 255)));
    endcase
  endtask

  // Noise: bad bases, characters while idle, raw bytes cut off by a new string.
  task automatic add_noise();
    case ($urandom_range(0, 2))
      0: begin
        begin_string($urandom_range(0, 1) ? BASE_ONE : RADIX_BITS'($urandom_range(37, 63)));
        add_char(CH_BITS'($urandom_range(0, 255)));
      end
      1: begin
        repeat ($urandom_range(1, 3)) push_char(CH_BITS'($urandom_range(0, 255)), 1'b0, '0);
      end
      default: begin
        begin_string(RADIX_BITS'($urandom_range(0, 63)));
        repeat ($urandom_range(1, 6)) add_char(CH_BITS'($urandom_range(0, 255)));
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Traffic shaping: four modes, cycled by accepted character count.
  //   0: no idling, 1: sender idle 81%, 2: receiver stall 81%, 3: both 38%
  // ---------------------------------------------------------------------------
  function automatic int sender_idle_pct(input int mode);
    case (mode)
      1: return 81;
      3: return 38;
      default: return 0;
    endcase
  endfunction

  function automatic int receiver_stall_pct(input int mode);
    case (mode)
      2: return 81;
      3: return 38;
      default: return 0;
    endcase
  endfunction

  int traffic_mode;
  assign traffic_mode = (chars_accepted / MODE_SPAN) % 4;

  // Driver: advances on each accepted input transaction and feeds the
  // predictor with the character that was just taken.
  always @(posedge clk) begin : drive_chars
    in_item_t taken;
    in_item_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        taken.ch = in_tdata[CH_BITS-1:0];
        taken.radix = in_tdata[CH_BITS +: RADIX_BITS];
        taken.first = in_tuser;
        predict_char(taken);
        chars_accepted <= chars_accepted + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_chars.size() > 0 &&
            $urandom_range(0, 99) >= sender_idle_pct(traffic_mode)) begin
          nxt = pending_chars.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {{(IN_DATA_W-CH_BITS-RADIX_BITS){1'b0}}, nxt.radix, nxt.ch};
          in_tuser <= nxt.first;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver backpressure.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= receiver_stall_pct(traffic_mode));
    end
  end

  // Monitor: every result transaction is checked against the oldest
  // expectation, field by field.
  always @(posedge clk) begin : check_results
    result_t want;
    result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.value      = out_tdata[VALUE_BITS-1:0];
      got.end_offset = out_tdata[VALUE_BITS +: OFFSET_BITS];
      got.converted  = out_tuser[0];
      got.overflowed = out_tuser[1];
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result value=%h end_offset=%0d converted=%b overflowed=%b",
                 $time, got.value, got.end_offset, got.converted, got.overflowed);
        mismatch_count = mismatch_count + 1;
      end else begin
        want = expected_results.pop_front();
        if (got.value !== want.value) begin
          $display("%0t: value expected %h actual %h", $time, want.value, got.value);
          mismatch_count = mismatch_count + 1;
        end
        if (got.end_offset !== want.end_offset) begin
          $display("%0t: end_offset expected %0d actual %0d",
                   $time, want.end_offset, got.end_offset);
          mismatch_count = mismatch_count + 1;
        end
        if (got.converted !== want.converted) begin
          $display("%0t: converted expected %b actual %b",
                   $time, want.converted, got.converted);
          mismatch_count = mismatch_count + 1;
        end
        if (got.overflowed !== want.overflowed) begin
          $display("%0t: overflowed expected %b actual %b",
                   $time, want.overflowed, got.overflowed);
          mismatch_count = mismatch_count + 1;
        end
      end
    end
  end

  // Watchdog: too long without any transaction means the DUT is hung.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    // Directed strings.
    push_char(8'h61, 1'b1, BASE_ONE);           // bad base 1
    push_char("7", 1'b1, 6'h3F);                // bad base 63
    push_char("Z", 1'b0, BASE_AUTO);            // ignored while idle
    add_text("\t-0x1fG", BASE_AUTO);            // blank, sign, hex prefix: -31
    add_text("0xz", BASE_HEX);                  // 0x with no hex digit after
    add_text("017", BASE_AUTO);                 // octal from leading zero
    add_char(CH_NUL);
    add_text("12", BASE_DEC);                   // abandoned by the next first
    add_text("- 5", BASE_DEC);                  // blank after sign ends parse
    add_text("-zzzzzzz", BASE_MAX);             // saturates despite minus
    add_char(CH_ALL);

    // Random part: mostly well-formed numbers, some noise.
    for (int i = 0; i < RANDOM_CHARS; ) begin
      i = i - pending_chars.size();
      if ($urandom_range(0, 99) < 85) begin
        add_number();
      end else begin
        add_noise();
      end
      i = i + pending_chars.size();
    end
    push_char(CH_NUL, 1'b0, BASE_AUTO);         // closes anything left open

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_chars.size() > 0 || in_tvalid || expected_results.size() > 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
